// File: design/six_sector_ring_colour_defines.svh
// Assertion macros used by the checker file of the ring colour block.
`ifndef SIX_SECTOR_RING_COLOUR_DEFINES_SVH
`define SIX_SECTOR_RING_COLOUR_DEFINES_SVH

// Check a property on every edge outside reset.
`define SCR_ASSERT_RUN(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ring colour check failed");

// Check a property on every edge, reset included.
`define SCR_ASSERT_ALL(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("ring colour reset check failed");

`endif

// File: design/scr_pkg.sv
// Shared types, constants and the square root step of the ring colour block.
`timescale 1ns / 1ps

package scr_pkg;

    localparam int FRAC_BITS_DEF = 12;
    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 32;

    localparam int COORD_W     = 16;
    localparam int SQ_W        = 32;
    localparam int RA_W        = 16;
    localparam int SQRT_STAGES = 16;

    localparam int SECTOR_MUL_Y = 1732;
    localparam int SECTOR_MUL_X = 1000;

    localparam logic [2:0] ON_RED     = 3'b001;
    localparam logic [2:0] ON_GREEN   = 3'b010;
    localparam logic [2:0] ON_BLUE    = 3'b100;
    localparam logic [2:0] ON_YELLOW  = 3'b011;
    localparam logic [2:0] ON_MAGENTA = 3'b101;
    localparam logic [2:0] ON_CYAN    = 3'b110;

    localparam logic [7:0] CH_FULL = 8'hFF;
    localparam logic [7:0] CH_ZERO = 8'h00;

    typedef struct packed {
        logic [SQ_W-1:0] sum_sq;
        logic [2:0]      on;
    } mid_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
    } sq_state_t;

    typedef enum logic [2:0] {
        RING_WHITE,
        RING_BLACK,
        RING_INNER,
        RING_MIDDLE,
        RING_OUTER
    } ring_t;

    function automatic logic [SQ_W-1:0] sqrt_bit(input int k);
        logic [SQ_W-1:0] one_w;
        one_w = SQ_W'(1);
        return one_w << (SQ_W - 2 - 2 * k);
    endfunction

    function automatic sq_state_t sqrt_step(input sq_state_t st,
                                            input logic [SQ_W-1:0] bitv);
        logic [SQ_W:0] trial;
        sq_state_t     nx;
        trial = {1'b0, st.root} + {1'b0, bitv};
        if ({1'b0, st.rem} >= trial)
        begin
            nx.rem  = st.rem - trial[SQ_W-1:0];
            nx.root = (st.root >> 1) + bitv;
        end
        else
        begin
            nx.rem  = st.rem;
            nx.root = st.root >> 1;
        end
        return nx;
    endfunction

endpackage

// File: design/scr_fifo.sv
// Small register queue with push/full and pop/empty sides.
`timescale 1ns / 1ps

module scr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next  = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: design/scr_front.sv
// Front end: accepts points, forms the squared radius and picks the sector.
`timescale 1ns / 1ps

module scr_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic signed [15:0]         x_coord,
    input  logic signed [15:0]         y_coord,
    output logic                       mq_push,
    input  logic                       mq_full,
    output scr_pkg::mid_item_t         mq_data
);

    logic                      f1_valid_reg, f1_valid_next;
    logic [30:0]               sqx_reg, sqx_next;
    logic [30:0]               sqy_reg, sqy_next;
    logic signed [27:0]        yl_reg, yl_next;
    logic signed [26:0]        xl_reg, xl_next;
    logic                      xpos_reg, xpos_next;

    logic                      f2_valid_reg, f2_valid_next;
    scr_pkg::mid_item_t        f2_item_reg, f2_item_next;

    logic                      f1_adv;
    logic                      f2_adv;
    logic                      accept;
    logic signed [31:0]        x_ext;
    logic signed [31:0]        y_ext;
    logic signed [31:0]        sqx_full;
    logic signed [31:0]        sqy_full;
    logic signed [27:0]        y_ext28;
    logic signed [26:0]        x_ext27;
    logic signed [28:0]        yl_w;
    logic signed [28:0]        xl_w;
    logic signed [28:0]        nxl_w;

    assign f2_adv  = !f2_valid_reg || !mq_full;
    assign f1_adv  = !f1_valid_reg || f2_adv;
    assign accept  = push && f1_adv;
    assign full    = !f1_adv;
    assign mq_push = f2_valid_reg && !mq_full;
    assign mq_data = f2_item_reg;

    always_comb
    begin
        x_ext    = {{16{x_coord[15]}}, x_coord};
        y_ext    = {{16{y_coord[15]}}, y_coord};
        sqx_full = x_ext * x_ext;
        sqy_full = y_ext * y_ext;
        y_ext28  = {{12{y_coord[15]}}, y_coord};
        x_ext27  = {{11{x_coord[15]}}, x_coord};

        f1_valid_next = f1_adv ? accept : f1_valid_reg;
        sqx_next      = accept ? sqx_full[30:0] : sqx_reg;
        sqy_next      = accept ? sqy_full[30:0] : sqy_reg;
        yl_next       = accept ? y_ext28 * 28'(scr_pkg::SECTOR_MUL_Y) : yl_reg;
        xl_next       = accept ? x_ext27 * 27'(scr_pkg::SECTOR_MUL_X) : xl_reg;
        xpos_next     = accept ? (!x_coord[15] && (x_coord != '0)) : xpos_reg;
    end

    always_comb
    begin
        yl_w  = {yl_reg[27], yl_reg};
        xl_w  = {{2{xl_reg[26]}}, xl_reg};
        nxl_w = -xl_w;

        f2_item_next.sum_sq = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        if (xpos_reg)
        begin
            priority if (yl_w < nxl_w)
                f2_item_next.on = scr_pkg::ON_MAGENTA;
            else if (yl_w > xl_w)
                f2_item_next.on = scr_pkg::ON_YELLOW;
            else
                f2_item_next.on = scr_pkg::ON_RED;
        end
        else
        begin
            priority if (yl_w < xl_w)
                f2_item_next.on = scr_pkg::ON_BLUE;
            else if (yl_w > nxl_w)
                f2_item_next.on = scr_pkg::ON_GREEN;
            else
                f2_item_next.on = scr_pkg::ON_CYAN;
        end
        if (!(f2_adv && f1_valid_reg))
        begin
            f2_item_next = f2_item_reg;
        end
        f2_valid_next = f2_adv ? f1_valid_reg : f2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= f1_valid_next;
            f2_valid_reg <= f2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sqx_reg     <= sqx_next;
        sqy_reg     <= sqy_next;
        yl_reg      <= yl_next;
        xl_reg      <= xl_next;
        xpos_reg    <= xpos_next;
        f2_item_reg <= f2_item_next;
    end

endmodule

// File: design/scr_back.sv
// Back end: pipelined square root, ring selection and colour mixing.
`timescale 1ns / 1ps

module scr_back #(
    parameter int FRAC_BITS = scr_pkg::FRAC_BITS_DEF,
    parameter int OUT_DEPTH = scr_pkg::OUT_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                mq_empty,
    input  scr_pkg::mid_item_t  mq_data,
    output logic                mq_pop,
    input  logic                out_pop_fire,
    output logic                res_valid,
    output scr_pkg::rgb_t       res_data
);

    localparam int NS = scr_pkg::SQRT_STAGES;
    localparam int CW = $clog2(OUT_DEPTH + 1);
    localparam int AW = (FRAC_BITS + 3 > scr_pkg::RA_W + 1) ? FRAC_BITS + 3
                                                              : scr_pkg::RA_W + 1;
    localparam int DW = FRAC_BITS + 1;
    localparam int PW = DW + 8;

    localparam logic [AW-1:0] ONE        = AW'(1) << FRAC_BITS;
    localparam logic [AW-1:0] WHITE_LIM  = ONE >> 2;
    localparam logic [AW-1:0] INNER_LIM  = (ONE * 3) >> 2;
    localparam logic [AW-1:0] MIDDLE_LIM = (ONE * 5) >> 2;
    localparam logic [AW-1:0] BLACK_LIM  = ONE << 1;
    localparam logic [AW-1:0] INNER_TOP  = (ONE >> 1) * 3;

    logic [CW-1:0]           cnt_reg, cnt_next;
    logic                    issue;

    logic [NS:0]             sv_reg, sv_next;
    scr_pkg::sq_state_t      sq_reg [0:NS];
    scr_pkg::sq_state_t      sq_next [0:NS];
    logic [2:0]              on_reg [0:NS];
    logic [2:0]              on_next [0:NS];

    logic                    c1_valid_reg, c1_valid_next;
    scr_pkg::ring_t          ring_reg, ring_next;
    logic [DW-1:0]           d_reg, d_next;
    logic [2:0]              c1_on_reg, c1_on_next;

    logic                    c2_valid_reg, c2_valid_next;
    scr_pkg::rgb_t           rgb_reg, rgb_next;

    logic [AW-1:0]           ra_w;
    logic [AW-1:0]           d1;
    logic [AW-1:0]           d2;
    logic [PW-1:0]           prod;
    logic [7:0]              v;
    logic [7:0]              ch [0:2];

    assign issue     = !mq_empty && (cnt_reg < CW'(OUT_DEPTH));
    assign mq_pop    = issue;
    assign res_valid = c2_valid_reg;
    assign res_data  = rgb_reg;

    always_comb
    begin
        cnt_next = cnt_reg + CW'(issue) - CW'(out_pop_fire);
    end

    always_comb
    begin
        sv_next       = {sv_reg[NS-1:0], issue};
        sq_next[0].rem  = mq_data.sum_sq;
        sq_next[0].root = '0;
        on_next[0]    = mq_data.on;
        for (int k = 0; k < NS; k++)
        begin
            sq_next[k+1] = scr_pkg::sqrt_step(sq_reg[k], scr_pkg::sqrt_bit(k));
            on_next[k+1] = on_reg[k];
        end
    end

    always_comb
    begin
        ra_w = {{(AW - scr_pkg::RA_W){1'b0}}, sq_reg[NS].root[scr_pkg::RA_W-1:0]};
        d1   = INNER_TOP - (ra_w << 1);
        d2   = BLACK_LIM - ra_w;
        priority if (ra_w < WHITE_LIM)
            ring_next = scr_pkg::RING_WHITE;
        else if (ra_w > BLACK_LIM)
            ring_next = scr_pkg::RING_BLACK;
        else if (ra_w < INNER_LIM)
            ring_next = scr_pkg::RING_INNER;
        else if (ra_w < MIDDLE_LIM)
            ring_next = scr_pkg::RING_MIDDLE;
        else
            ring_next = scr_pkg::RING_OUTER;
        d_next        = (ring_next == scr_pkg::RING_INNER) ? d1[DW-1:0] : d2[DW-1:0];
        c1_on_next    = on_reg[NS];
        c1_valid_next = sv_reg[NS];
    end

    always_comb
    begin
        prod = {d_reg, 8'h00} - {8'h00, d_reg};
        v    = (ring_reg == scr_pkg::RING_INNER) ? prod[FRAC_BITS+7:FRAC_BITS]
                                                 : prod[FRAC_BITS+8:FRAC_BITS+1];
        for (int k = 0; k < 3; k++)
        begin
            unique case (ring_reg)
                scr_pkg::RING_WHITE:  ch[k] = scr_pkg::CH_FULL;
                scr_pkg::RING_BLACK:  ch[k] = scr_pkg::CH_ZERO;
                scr_pkg::RING_INNER:  ch[k] = c1_on_reg[k] ? scr_pkg::CH_FULL : v;
                scr_pkg::RING_MIDDLE: ch[k] = c1_on_reg[k] ? scr_pkg::CH_FULL
                                                           : scr_pkg::CH_ZERO;
                scr_pkg::RING_OUTER:  ch[k] = c1_on_reg[k] ? v : scr_pkg::CH_ZERO;
                default:              ch[k] = scr_pkg::CH_ZERO;
            endcase
        end
        rgb_next.red   = ch[0];
        rgb_next.green = ch[1];
        rgb_next.blue  = ch[2];
        c2_valid_next  = c1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            sv_reg       <= '0;
            c1_valid_reg <= 1'b0;
            c2_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            sv_reg       <= sv_next;
            c1_valid_reg <= c1_valid_next;
            c2_valid_reg <= c2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= NS; k++)
        begin
            sq_reg[k] <= sq_next[k];
            on_reg[k] <= on_next[k];
        end
        ring_reg  <= ring_next;
        d_reg     <= d_next;
        c1_on_reg <= c1_on_next;
        rgb_reg   <= rgb_next;
    end

endmodule

// File: design/six_sector_ring_colour.sv
// Top level of the six sector ring colour block.
// Usage:
//   Input side is a queue: drive x_coord/y_coord (signed, FRAC_BITS fraction
//   bits) with push; a request is taken on an edge where push is high and
//   full is low. Output side is a queue: while empty is low, red/green/blue
//   show the oldest colour; pop on an edge with empty low takes it.
//   A request passes the front end stages, the middle queue write, the
//   issue register, the 16-stage square root, the 2-stage colour stage and
//   the result queue write before its colour shows with empty low.
//   Throughput: one request per cycle while results are popped each cycle.
//   The back end only issues a request when the result queue has a slot
//   reserved for it, so a stalled receiver fills the result queue
//   (OUT_DEPTH entries), then the middle queue and front end, and then raises
//   full; nothing is dropped.
//   Reset: asynchronous, active low; all queues empty, full low.
`timescale 1ns / 1ps

module six_sector_ring_colour #(
    parameter int FRAC_BITS = scr_pkg::FRAC_BITS_DEF,
    parameter int MID_DEPTH = scr_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = scr_pkg::OUT_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [15:0] x_coord,
    input  logic signed [15:0] y_coord,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue
);

    localparam int MID_W = $bits(scr_pkg::mid_item_t);
    localparam int RGB_W = $bits(scr_pkg::rgb_t);

    logic               mq_push;
    logic               mq_full;
    logic               mq_pop;
    logic               mq_empty;
    scr_pkg::mid_item_t mq_wdata;
    scr_pkg::mid_item_t mq_rdata;
    logic               res_valid;
    scr_pkg::rgb_t      res_data;
    scr_pkg::rgb_t      out_data;
    logic               out_full;
    logic               out_pop_fire;

    assign out_pop_fire = pop && !empty;
    assign red          = out_data.red;
    assign green        = out_data.green;
    assign blue         = out_data.blue;

    scr_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .x_coord (x_coord),
        .y_coord (y_coord),
        .mq_push (mq_push),
        .mq_full (mq_full),
        .mq_data (mq_wdata)
    );

    scr_fifo #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mq_push),
        .full  (mq_full),
        .wdata (mq_wdata),
        .pop   (mq_pop),
        .empty (mq_empty),
        .rdata (mq_rdata)
    );

    scr_back #(
        .FRAC_BITS (FRAC_BITS),
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .mq_empty     (mq_empty),
        .mq_data      (mq_rdata),
        .mq_pop       (mq_pop),
        .out_pop_fire (out_pop_fire),
        .res_valid    (res_valid),
        .res_data     (res_data)
    );

    scr_fifo #(
        .WIDTH (RGB_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_valid),
        .full  (out_full),
        .wdata (res_data),
        .pop   (pop),
        .empty (empty),
        .rdata (out_data)
    );

    logic unused_out_full;
    assign unused_out_full = out_full;

endmodule

// File: design/scr_checker.sv
// Port-level checks for the ring colour block and their bind.
`timescale 1ns / 1ps
`include "six_sector_ring_colour_defines.svh"

module scr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  red,
    input logic [7:0]  green,
    input logic [7:0]  blue
);

    logic        shape_ok;
    logic [23:0] colour;

    assign colour   = {red, green, blue};
    assign shape_ok = (red == 8'hFF) || (green == 8'hFF) || (blue == 8'hFF) ||
                      (((red == 8'h00) || (green == 8'h00) || (red == green)) &&
                       ((red == 8'h00) || (blue == 8'h00) || (red == blue)) &&
                       ((green == 8'h00) || (blue == 8'h00) || (green == blue)));

    // Hold a waiting result until it is popped.
    `SCR_ASSERT_RUN(a_result_kept, !empty && !pop |=> !empty)
    `SCR_ASSERT_RUN(a_result_stable, !empty && !pop |=> $stable(colour))
    // Every colour is white, black, a tint, a pure sector colour or a shade.
    `SCR_ASSERT_RUN(a_colour_shape, !empty |-> shape_ok)
    // Drop everything at reset.
    `SCR_ASSERT_ALL(a_reset_empty, !rst_n |=> empty && !full)

endmodule

bind six_sector_ring_colour scr_checker u_scr_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .red     (red),
    .green   (green),
    .blue    (blue)
);
